// ===== hdl/dofifo_pkg.sv =====
// shared types and constants for the drop-oldest fifo
package dofifo_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    localparam logic [6:0] CAPACITY_RESET = 7'd32;
    localparam int         CMD_WIDTH      = 2;
    localparam int         PORT_WORD      = 32;
    localparam int         FILL_WIDTH     = 7;

endpackage

// ===== hdl/dofifo_cell.sv =====
// one storage cell of the shifting word chain
module dofifo_cell #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  dofifo_pkg::t_cell_ctrl  i_ctrl,
    input  logic [WORD_WIDTH-1:0]   i_neighbour,
    input  logic [WORD_WIDTH-1:0]   i_new_word,
    output logic [WORD_WIDTH-1:0]   o_word
);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctrl.load) begin
            n_word = i_new_word;
        end else if (i_ctrl.shift) begin
            n_word = i_neighbour;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ===== hdl/drop_oldest_fifo_with_flush.sv =====
// top level of the drop-oldest fifo with flush
// Words are held in a row of cells, oldest in the first cell; every removal of
// the oldest word shifts the whole row down by one cell in the same cycle.
// Push, pop and clear each finish with their own transfer. A push into a full
// store emits the oldest word and appends the new one in that same cycle. A
// flush is drained by the single output register, which takes the chain head
// one word at a time, and no input transfer is taken until the last word has
// been emitted. Input is also held off while the output register holds a word
// that is not taken in that cycle.
// Writing a non-zero capacity empties the store; zero is ignored and values
// above DEPTH saturate to DEPTH. No clearing pass is needed after reset.
module drop_oldest_fifo_with_flush #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // data_word
    input  logic [1:0]  i_s_tuser,   // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // data_word_res, fill_count, zero pad
    output logic        o_m_tlast,   // last_of_burst
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data   // capacity
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KEEP = (WORD_WIDTH < dofifo_pkg::PORT_WORD) ? WORD_WIDTH
                                                                : dofifo_pkg::PORT_WORD;
    localparam logic [6:0]    DEPTH_7   = 7'(DEPTH);
    localparam logic [CW-1:0] CAP_RESET =
        (dofifo_pkg::CAPACITY_RESET > DEPTH_7) ? CW'(DEPTH)
                                               : CW'(dofifo_pkg::CAPACITY_RESET);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_cap, n_cap;
    logic          r_flush, n_flush;
    logic          r_out_valid, n_out_valid;
    logic [WORD_WIDTH-1:0] r_out_word, n_out_word;
    logic          r_out_last, n_out_last;
    logic [CW-1:0] r_out_fill, n_out_fill;

    logic [WORD_WIDTH-1:0] w_word [DEPTH];
    logic [WORD_WIDTH-1:0] w_new_word;
    logic          w_out_free;
    logic          w_in_fire;
    logic          w_cfg_fire;
    logic          w_shift;
    logic          w_load;
    logic [CW-1:0] w_load_idx;
    dofifo_pkg::t_cmd w_cmd;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_flush && w_out_free;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;
    assign w_cmd      = dofifo_pkg::t_cmd'(i_s_tuser);
    assign w_new_word = WORD_WIDTH'(i_s_tdata[KEEP-1:0]);

    always_comb begin
        n_count     = r_count;
        n_cap       = r_cap;
        n_flush     = r_flush;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;
        n_out_fill  = r_out_fill;
        w_shift     = 1'b0;
        w_load      = 1'b0;

        if (r_flush) begin
            if (w_out_free) begin
                w_shift     = 1'b1;
                n_out_valid = 1'b1;
                n_out_word  = w_word[0];
                n_out_fill  = r_count - CW'(1);
                n_out_last  = (r_count == CW'(1));
                n_count     = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_flush = 1'b0;
                end
            end
        end else if (w_in_fire) begin
            case (w_cmd)
                dofifo_pkg::CMD_PUSH: begin
                    w_load = 1'b1;
                    if (r_count >= r_cap) begin
                        w_shift     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_word  = w_word[0];
                        n_out_fill  = r_count - CW'(1);
                        n_out_last  = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                dofifo_pkg::CMD_POP: begin
                    if (r_count != '0) begin
                        w_shift     = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_word  = w_word[0];
                        n_out_fill  = r_count - CW'(1);
                        n_out_last  = 1'b1;
                        n_count     = r_count - CW'(1);
                    end
                end
                dofifo_pkg::CMD_FLUSH: begin
                    n_flush = (r_count != '0);
                end
                dofifo_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end

        if (w_cfg_fire && (i_cfg_data != 7'd0)) begin
            n_cap   = (i_cfg_data > DEPTH_7) ? CW'(DEPTH) : CW'(i_cfg_data);
            n_count = '0;
            n_flush = 1'b0;
        end
    end

    assign w_load_idx = w_shift ? (r_count - CW'(1)) : r_count;

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            dofifo_pkg::t_cell_ctrl w_ctrl;
            logic [WORD_WIDTH-1:0]  w_next;

            assign w_ctrl = '{shift: w_shift, load: w_load && (w_load_idx == CW'(i))};

            if (i == DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_word[i+1];
            end

            dofifo_cell #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_neighbour (w_next),
                .i_new_word  (w_new_word),
                .o_word      (w_word[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
        r_out_fill <= n_out_fill;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0,
                         dofifo_pkg::FILL_WIDTH'(r_out_fill),
                         dofifo_pkg::PORT_WORD'(r_out_word[KEEP-1:0])};

endmodule
